### sv/joystick_to_wheel_speed_mixer_defines.svh
// Shared assertion macros for the wheel speed mixer.
`ifndef JOYSTICK_TO_WHEEL_SPEED_MIXER_DEFINES_SVH
`define JOYSTICK_TO_WHEEL_SPEED_MIXER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JTWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define JTWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/jtws_pkg.sv
`default_nettype none

package jtws_pkg;

	localparam int PEDAL_W = 13;
	localparam int ANGLE_W = 12;
	localparam int MAXSPD_W = 14;
	localparam int DBAND_W = 13;
	localparam int SPD_W = 14;
	localparam int OUT_W = 15;
	localparam int K_W = 10;
	localparam int SK_W = SPD_W + K_W;

	localparam logic [ANGLE_W-1:0] ANG_QUARTER = 12'd900;
	localparam logic [ANGLE_W-1:0] ANG_HALF = 12'd1800;
	localparam logic [ANGLE_W-1:0] ANG_THREE_Q = 12'd2700;
	localparam logic [ANGLE_W-1:0] ANG_FULL = 12'd3600;

	localparam logic [SPD_W-1:0] SPEED_LIMIT = 14'd10000;
	localparam logic [K_W-1:0] K_MAX = 10'd900;

	// floor(x / 900) == (x * RECIP_900) >> RECIP_SHIFT for every x below 2^24
	localparam int RECIP_W = 25;
	localparam int RECIP_SHIFT = 34;
	localparam logic [RECIP_W-1:0] RECIP_900 = 25'd19088744;

	localparam logic [MAXSPD_W-1:0] FULL_SCALE_RST = 14'd1000;
	localparam logic [DBAND_W-1:0] DEADBAND_RST = 13'd205;

	localparam logic REG_FULL_SCALE = 1'b0;
	localparam logic REG_DEADBAND = 1'b1;

	typedef enum logic [2:0] {
		SIDE_ZERO,
		SIDE_POS,
		SIDE_NEG,
		SIDE_POS_CURVE,
		SIDE_NEG_CURVE
	} side_t;

	typedef struct packed {
		side_t left_sel;
		side_t right_sel;
		logic  no_rule;
	} ctrl_t;

	typedef struct packed {
		ctrl_t              ctrl;
		logic [PEDAL_W-1:0] pedal;
		logic [K_W-1:0]     k;
	} dec_t;

	typedef struct packed {
		ctrl_t            ctrl;
		logic [SPD_W-1:0] spd;
		logic [SPD_W-1:0] q;
	} arith_t;

endpackage

`default_nettype wire

### sv/joystick_to_wheel_speed_mixer.sv
// Joystick to wheel speed mixer for a six-wheel skid-steer base.
// Input stream (s_t*): one joystick sample per transaction; s_tdata carries
//   front pedal and back pedal (Q1.12) and stick angle (0.1 degree units).
// Output stream (m_t*): one result per sample, in order; m_tdata carries the
//   left and right side speeds in mm/s (two's complement), m_tuser raises
//   when no sector rule covered the sample and both speeds are forced to 0.
// APB port: full-scale speed at byte 0, deadband at byte 4; write only while idle.
// Pipeline: 5 register stages (decode, scale by full-scale speed, multiply
//   by angle offset, reciprocal divide by 900, mix); m_tvalid comes from
//   the mix stage register.
// Throughput: one sample per cycle while m_tready is high; each of the five
//   pipeline registers holds one sample, and one multiplier in each of stages 2 to 4 sets the depth.
// Stall: when m_tready is low the last stage holds its result; earlier
//   stages keep filling until each holds a sample, so the pipeline holds
//   five samples in all before s_tready drops.
// Reset: pipeline empties, full-scale speed returns to 1000 and deadband to 205.
`default_nettype none

module joystick_to_wheel_speed_mixer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // [12:0] front_pedal, [25:13] back_pedal,
	                                   // [37:26] stick_angle, [39:38] zero
	// master stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [14:0] left_speed, [29:15] right_speed,
	                                   // [31:30] zero
	output logic [0:0]       m_tuser,  // [0] no_rule
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [jtws_pkg::MAXSPD_W-1:0] full_scale_q;
	logic [jtws_pkg::DBAND_W-1:0]  deadband_q;
	logic                          reg_sel;

	logic                          dec_valid, dec_ready;
	jtws_pkg::dec_t                dec_data;
	logic                          ar_valid, ar_ready;
	jtws_pkg::arith_t              ar_data;
	logic signed [jtws_pkg::OUT_W-1:0] left_speed, right_speed;
	logic                          no_rule;

	// Registers: word addressed, low address bits ignored.
	assign pready = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= jtws_pkg::FULL_SCALE_RST;
			deadband_q <= jtws_pkg::DEADBAND_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				jtws_pkg::REG_FULL_SCALE: full_scale_q <= pwdata[jtws_pkg::MAXSPD_W-1:0];
				jtws_pkg::REG_DEADBAND:   deadband_q <= pwdata[jtws_pkg::DBAND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			jtws_pkg::REG_FULL_SCALE: prdata = 32'(full_scale_q);
			jtws_pkg::REG_DEADBAND:   prdata = 32'(deadband_q);
			default:                  prdata = '0;
		endcase
	end

	// Stage 1: pedal classification and angle sector decode.
	jtws_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.front_pedal (s_tdata[12:0]),
		.back_pedal  (s_tdata[25:13]),
		.stick_angle (s_tdata[37:26]),
		.deadband    (deadband_q),
		.out_valid   (dec_valid),
		.out_ready   (dec_ready),
		.out_data    (dec_data)
	);

	// Stages 2 to 4: speed scaling, curve product, divide by 900.
	jtws_arith u_arith (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (dec_valid),
		.in_ready   (dec_ready),
		.in_data    (dec_data),
		.full_scale (full_scale_q),
		.out_valid  (ar_valid),
		.out_ready  (ar_ready),
		.out_data   (ar_data)
	);

	// Stage 5: side mixing into the output register.
	jtws_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (ar_valid),
		.in_ready    (ar_ready),
		.in_data     (ar_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.no_rule     (no_rule)
	);

	assign m_tdata = {2'b00, right_speed, left_speed};
	assign m_tuser = no_rule;

endmodule

`default_nettype wire

### sv/jtws_decode.sv
`default_nettype none

module jtws_decode (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [jtws_pkg::PEDAL_W-1:0]    front_pedal,
	input  wire logic [jtws_pkg::PEDAL_W-1:0]    back_pedal,
	input  wire logic [jtws_pkg::ANGLE_W-1:0]    stick_angle,
	input  wire logic [jtws_pkg::DBAND_W-1:0]    deadband,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output jtws_pkg::dec_t                       out_data
);

	logic            fa, ba, fi, bi;
	jtws_pkg::dec_t  dec;
	logic            valid_s1;
	jtws_pkg::dec_t  dec_s1;

	always_comb begin
		fa = front_pedal > deadband;
		ba = back_pedal > deadband;
		fi = front_pedal < deadband;
		bi = back_pedal < deadband;

		dec.ctrl.left_sel = jtws_pkg::SIDE_ZERO;
		dec.ctrl.right_sel = jtws_pkg::SIDE_ZERO;
		dec.ctrl.no_rule = 1'b0;
		dec.pedal = fa ? front_pedal : back_pedal;
		dec.k = '0;

		if ((fi && bi) || (fa && ba)) begin
			dec.ctrl.no_rule = 1'b0;
		end else if (fa) begin
			if (stick_angle <= jtws_pkg::ANG_QUARTER) begin
				dec.ctrl.left_sel = jtws_pkg::SIDE_POS_CURVE;
				dec.ctrl.right_sel = jtws_pkg::SIDE_POS;
				dec.k = jtws_pkg::K_W'(jtws_pkg::ANG_QUARTER - stick_angle);
			end else if (stick_angle <= jtws_pkg::ANG_HALF) begin
				dec.ctrl.left_sel = jtws_pkg::SIDE_POS;
				dec.ctrl.right_sel = jtws_pkg::SIDE_POS_CURVE;
				dec.k = jtws_pkg::K_W'(stick_angle - jtws_pkg::ANG_QUARTER);
			end else if (stick_angle <= jtws_pkg::ANG_THREE_Q) begin
				dec.ctrl.left_sel = jtws_pkg::SIDE_POS;
				dec.ctrl.right_sel = jtws_pkg::SIDE_NEG;
			end else if (stick_angle <= jtws_pkg::ANG_FULL) begin
				dec.ctrl.left_sel = jtws_pkg::SIDE_NEG;
				dec.ctrl.right_sel = jtws_pkg::SIDE_POS;
			end else begin
				dec.ctrl.no_rule = 1'b1;
			end
		end else if (ba) begin
			if (stick_angle == jtws_pkg::ANG_QUARTER) begin
				dec.ctrl.left_sel = jtws_pkg::SIDE_NEG;
				dec.ctrl.right_sel = jtws_pkg::SIDE_NEG;
			end else if (stick_angle > jtws_pkg::ANG_HALF &&
				stick_angle <= jtws_pkg::ANG_THREE_Q) begin
				dec.ctrl.left_sel = jtws_pkg::SIDE_NEG;
				dec.ctrl.right_sel = jtws_pkg::SIDE_NEG_CURVE;
				dec.k = jtws_pkg::K_W'(jtws_pkg::ANG_THREE_Q - stick_angle);
			end else if (stick_angle > jtws_pkg::ANG_THREE_Q &&
				stick_angle <= jtws_pkg::ANG_FULL) begin
				dec.ctrl.left_sel = jtws_pkg::SIDE_NEG_CURVE;
				dec.ctrl.right_sel = jtws_pkg::SIDE_NEG;
				dec.k = jtws_pkg::K_W'(stick_angle - jtws_pkg::ANG_THREE_Q);
			end else begin
				dec.ctrl.no_rule = 1'b1;
			end
		end else begin
			// a pedal exactly at the deadband with the other one not above it
			dec.ctrl.no_rule = 1'b1;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dec_s1 <= dec;
		end
	end

	assign out_valid = valid_s1;
	assign out_data = dec_s1;

endmodule

`default_nettype wire

### sv/jtws_arith.sv
`default_nettype none
`include "joystick_to_wheel_speed_mixer_defines.svh"

module jtws_arith (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire jtws_pkg::dec_t                   in_data,
	input  wire logic [jtws_pkg::MAXSPD_W-1:0]    full_scale,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output jtws_pkg::arith_t                      out_data
);

	localparam int PROD_W = jtws_pkg::PEDAL_W + jtws_pkg::MAXSPD_W;
	localparam int QP_W = jtws_pkg::SK_W + jtws_pkg::RECIP_W;

	logic [PROD_W-1:0]            prod;
	logic [PROD_W-13:0]           p_shr;
	logic [jtws_pkg::SPD_W-1:0]   spd_sat;
	logic [jtws_pkg::SK_W-1:0]    sk;
	logic [QP_W-1:0]              qp;

	logic                         valid_s2, valid_s3, valid_s4;
	logic                         ready_s3, ready_s4;
	jtws_pkg::ctrl_t              ctrl_s2, ctrl_s3, ctrl_s4;
	logic [jtws_pkg::K_W-1:0]     k_s2;
	logic [jtws_pkg::SPD_W-1:0]   spd_s2, spd_s3, spd_s4;
	logic [jtws_pkg::SK_W-1:0]    sk_s3;
	logic [jtws_pkg::SPD_W-1:0]   q_s4;

	// stage 2: pedal scaled by full-scale speed, Q1.12 fraction dropped, clamped
	assign prod = PROD_W'(in_data.pedal) * PROD_W'(full_scale);
	assign p_shr = prod[PROD_W-1:12];
	assign spd_sat = (p_shr > (PROD_W-12)'(jtws_pkg::SPEED_LIMIT)) ?
		jtws_pkg::SPEED_LIMIT : jtws_pkg::SPD_W'(p_shr);

	// stage 3: speed times angle offset
	assign sk = jtws_pkg::SK_W'(spd_s2) * jtws_pkg::SK_W'(k_s2);

	// stage 4: divide by 900 through the reciprocal
	assign qp = QP_W'(sk_s3) * QP_W'(jtws_pkg::RECIP_900);

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = !valid_s2 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctrl_s2 <= in_data.ctrl;
			k_s2 <= in_data.k;
			spd_s2 <= spd_sat;
		end
		if (ready_s3 && valid_s2) begin
			ctrl_s3 <= ctrl_s2;
			spd_s3 <= spd_s2;
			sk_s3 <= sk;
		end
		if (ready_s4 && valid_s3) begin
			ctrl_s4 <= ctrl_s3;
			spd_s4 <= spd_s3;
			q_s4 <= qp[jtws_pkg::RECIP_SHIFT +: jtws_pkg::SPD_W];
		end
	end

	assign out_valid = valid_s4;
	assign out_data.ctrl = ctrl_s4;
	assign out_data.spd = spd_s4;
	assign out_data.q = q_s4;

	`JTWS_ASSERT_IMP(a_spd_clamped, clk, arst_n, valid_s2, spd_s2 <= jtws_pkg::SPEED_LIMIT, "speed above limit")
	`JTWS_ASSERT_IMP(a_k_range, clk, arst_n, valid_s2, k_s2 <= jtws_pkg::K_MAX, "angle offset above 900")
	`JTWS_ASSERT_IMP(a_q_le_spd, clk, arst_n, valid_s4, q_s4 <= spd_s4, "quotient above speed")
	`JTWS_ASSERT_NXT(a_s4_hold, clk, arst_n, valid_s4 && !out_ready, valid_s4, "stalled item lost")

endmodule

`default_nettype wire

### sv/jtws_out.sv
`default_nettype none
`include "joystick_to_wheel_speed_mixer_defines.svh"

module jtws_out (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire jtws_pkg::arith_t              in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [jtws_pkg::OUT_W-1:0]  left_speed,
	output logic signed [jtws_pkg::OUT_W-1:0]  right_speed,
	output logic                               no_rule
);

	logic signed [jtws_pkg::OUT_W-1:0] sp, cv, left_v, right_v;
	logic                              valid_s5;
	logic signed [jtws_pkg::OUT_W-1:0] left_s5, right_s5;
	logic                              no_rule_s5;

	function automatic logic signed [jtws_pkg::OUT_W-1:0] side_val(
		input jtws_pkg::side_t             sel,
		input logic signed [jtws_pkg::OUT_W-1:0] s,
		input logic signed [jtws_pkg::OUT_W-1:0] c
	);
		case (sel)
			jtws_pkg::SIDE_POS:       side_val = s;
			jtws_pkg::SIDE_NEG:       side_val = -s;
			jtws_pkg::SIDE_POS_CURVE: side_val = c;
			jtws_pkg::SIDE_NEG_CURVE: side_val = -c;
			default:                  side_val = '0;
		endcase
	endfunction

	// stage 5: curve = s - s*k/900, then apply each side's sign
	assign sp = $signed({1'b0, in_data.spd});
	assign cv = $signed({1'b0, in_data.spd - in_data.q});
	assign left_v = side_val(in_data.ctrl.left_sel, sp, cv);
	assign right_v = side_val(in_data.ctrl.right_sel, sp, cv);

	assign in_ready = !valid_s5 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (in_ready) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			left_s5 <= left_v;
			right_s5 <= right_v;
			no_rule_s5 <= in_data.ctrl.no_rule;
		end
	end

	assign out_valid = valid_s5;
	assign left_speed = left_s5;
	assign right_speed = right_s5;
	assign no_rule = no_rule_s5;

	`JTWS_ASSERT_IMP(a_no_rule_zero, clk, arst_n, valid_s5 && no_rule_s5, left_s5 == '0 && right_s5 == '0, "speeds not zero without rule")

endmodule

`default_nettype wire

### verif/wheel_mix_checker.sv
`timescale 1ns / 1ps

module wheel_mix_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // [12:0] front_pedal, [25:13] back_pedal, [37:26] stick_angle
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // [14:0] left_speed, [29:15] right_speed
	input  logic [0:0]  m_tuser,  // [0] no_rule
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          backlog
);

	localparam int QTR = int'(jtws_pkg::ANG_QUARTER);
	localparam int HLF = int'(jtws_pkg::ANG_HALF);
	localparam int TQR = int'(jtws_pkg::ANG_THREE_Q);
	localparam int FUL = int'(jtws_pkg::ANG_FULL);

	typedef struct {
		logic [jtws_pkg::OUT_W-1:0] left_spd;
		logic [jtws_pkg::OUT_W-1:0] right_spd;
		logic                       no_rule;
	} wheel_cmd_t;

	wheel_cmd_t                     wheel_cmds[$];
	logic [jtws_pkg::MAXSPD_W-1:0]  full_scale_q = jtws_pkg::FULL_SCALE_RST;
	logic [jtws_pkg::DBAND_W-1:0]   deadband_q = jtws_pkg::DEADBAND_RST;

	initial begin
		mismatches = 0;
		backlog = 0;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Scale a pedal to a side speed, truncating, saturated at the speed limit.
	function automatic int pedal_speed(input int pedal);
		int raw;
		raw = (pedal * int'(full_scale_q)) >>> 12;
		return (raw > int'(jtws_pkg::SPEED_LIMIT)) ? int'(jtws_pkg::SPEED_LIMIT) : raw;
	endfunction

	function automatic int bend(input int spd, input int k);
		return spd - (spd * k) / QTR;
	endfunction

	function automatic wheel_cmd_t mix_wheel_speeds(input int front, input int back, input int ang);
		wheel_cmd_t cmd;
		int db;
		int spd;
		int lft;
		int rgt;
		bit fwd;
		bit rev;
		bit hit;
		db = deadband_q;
		lft = 0;
		rgt = 0;
		hit = 1'b1;
		fwd = front > db;
		rev = back > db;
		if ((front < db && back < db) || (fwd && rev)) begin
			hit = 1'b1;
		end else if (fwd) begin
			spd = pedal_speed(front);
			if (ang <= QTR) begin
				lft = bend(spd, QTR - ang);
				rgt = spd;
			end else if (ang <= HLF) begin
				lft = spd;
				rgt = bend(spd, ang - QTR);
			end else if (ang <= TQR) begin
				lft = spd;
				rgt = -spd;
			end else if (ang <= FUL) begin
				lft = -spd;
				rgt = spd;
			end else begin
				hit = 1'b0;
			end
		end else if (rev) begin
			spd = pedal_speed(back);
			if (ang == QTR) begin
				lft = -spd;
				rgt = -spd;
			end else if (ang > HLF && ang <= TQR) begin
				lft = -spd;
				rgt = -bend(spd, TQR - ang);
			end else if (ang > TQR && ang <= FUL) begin
				lft = -bend(spd, ang - TQR);
				rgt = -spd;
			end else begin
				hit = 1'b0;
			end
		end else begin
			hit = 1'b0;
		end
		cmd.left_spd = lft[jtws_pkg::OUT_W-1:0];
		cmd.right_spd = rgt[jtws_pkg::OUT_W-1:0];
		cmd.no_rule = !hit;
		return cmd;
	endfunction

	always @(posedge clk) begin
		wheel_cmd_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (wheel_cmds.size() == 0) begin
					flag_mismatch("result with no pending sample", int'(m_tdata), 0);
				end else begin
					want = wheel_cmds.pop_front();
					if (m_tdata[14:0] !== want.left_spd)
						flag_mismatch("left_speed", $signed(m_tdata[14:0]),
							$signed(want.left_spd));
					if (m_tdata[29:15] !== want.right_spd)
						flag_mismatch("right_speed", $signed(m_tdata[29:15]),
							$signed(want.right_spd));
					if (m_tuser[0] !== want.no_rule)
						flag_mismatch("no_rule", m_tuser[0], want.no_rule);
				end
			end
			if (s_tvalid && s_tready)
				wheel_cmds.insert(wheel_cmds.size(), mix_wheel_speeds(s_tdata[12:0],
					s_tdata[25:13], s_tdata[37:26]));
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == jtws_pkg::REG_DEADBAND)
					deadband_q = pwdata[jtws_pkg::DBAND_W-1:0];
				else
					full_scale_q = pwdata[jtws_pkg::MAXSPD_W-1:0];
			end
			backlog = wheel_cmds.size();
		end
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int LATENCY = 5;          // pipeline depth of the mixer
	localparam int STALL_LIMIT = 2000;   // cycles without any transaction before giving up
	localparam int CHOKE_CYCLES = 60;    // long receiver hold-off to back up the pipeline
	localparam int PHASE_ITEMS = 160;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // [12:0] front_pedal, [25:13] back_pedal, [37:26] stick_angle
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;       // [14:0] left_speed, [29:15] right_speed
	logic [0:0]  m_tuser;       // [0] no_rule
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int backlog;
	int quiet_cycles = 0;

	// Pacing state for each side: a run of items either idles at random or not at all.
	int tx_run = 0;
	bit tx_calm = 1'b0;
	bit tx_rush = 1'b0;
	int rx_run = 0;
	bit rx_calm = 1'b0;
	bit choke_req = 1'b0;

	always #10 clk = ~clk;

	joystick_to_wheel_speed_mixer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	wheel_mix_checker mix_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.mismatches (mismatches),
		.backlog    (backlog)
	);

	// Draw the idle cycles before the next transaction; switch between calm runs
	// (no idling at all) and runs with random gaps.
	function automatic int draw_pause(inout int run_left, inout bit calm);
		if (run_left == 0) begin
			calm = ($urandom_range(3, 0) == 0);
			run_left = $urandom_range(60, 10);
		end
		run_left--;
		return calm ? 0 : $urandom_range(8, 0);
	endfunction

	// Pedal value no higher than the deadband.
	function automatic int pedal_upto(input int db);
		return $urandom_range(db, 0);
	endfunction

	// Pedal value above the deadband, mostly no higher than 1.0 in Q1.12.
	function automatic int pedal_above(input int db);
		int lo;
		int hi;
		if (db >= 8191)
			return 8191;
		lo = db + 1;
		hi = (lo <= 4096 && $urandom_range(7, 0) != 0) ? 4096 : 8191;
		return $urandom_range(hi, lo);
	endfunction

	// Stick angle: mostly in range, often right on a sector border, sometimes past 3600.
	function automatic int pick_angle();
		int marks[14] = '{0, 1, 899, 900, 901, 1799, 1800, 1801, 2699, 2700, 2701,
			3599, 3600, 3601};
		int r;
		r = $urandom_range(9, 0);
		if (r < 6)
			return $urandom_range(3600, 0);
		if (r < 8)
			return marks[$urandom_range(13, 0)];
		return $urandom_range(4095, 0);
	endfunction

	function automatic logic [39:0] pack_sample(input int front, input int back, input int ang);
		logic [12:0] f;
		logic [12:0] b;
		logic [11:0] a;
		f = front[12:0];
		b = back[12:0];
		a = ang[11:0];
		return {2'b00, a, b, f};
	endfunction

	// Mostly one clean pedal with a random angle; the rest covers both pedals idle,
	// both pressed, a pedal sitting on the deadband and raw noise.
	function automatic logic [39:0] make_sample(input int db);
		int pick;
		int f;
		int b;
		pick = $urandom_range(99, 0);
		if (pick < 40) begin
			f = pedal_above(db);
			b = pedal_upto(db);
		end else if (pick < 70) begin
			f = pedal_upto(db);
			b = pedal_above(db);
		end else if (pick < 78) begin
			f = pedal_upto(db);
			b = pedal_upto(db);
		end else if (pick < 85) begin
			f = pedal_above(db);
			b = pedal_above(db);
		end else if (pick < 92) begin
			f = ($urandom_range(1, 0) != 0) ? db : pedal_upto(db);
			b = (f == db) ? pedal_upto(db) : db;
		end else begin
			f = $urandom_range(8191, 0);
			b = $urandom_range(8191, 0);
		end
		return pack_sample(f, b, pick_angle());
	endfunction

	// Offer one sample and hold it until the mixer takes it.
	task automatic push_sample(input logic [39:0] smp);
		int gap;
		gap = draw_pause(tx_run, tx_calm);
		if (tx_rush)
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Drop valid, wait for every outstanding result, then let the pipeline run dry.
	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		while (backlog != 0) @(negedge clk);
		repeat (LATENCY + 3) @(negedge clk);
	endtask

	task automatic write_reg(input logic sel, input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		int gap;
		forever begin
			if (choke_req) begin
				choke_req = 1'b0;
				m_tready <= 1'b0;
				repeat (CHOKE_CYCLES) @(negedge clk);
			end
			gap = draw_pause(rx_run, rx_calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Count cycles in which neither stream moves a transaction.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		// front, back, angle under the reset settings (full scale 1000, deadband 205)
		int dir_set[25][3] = '{
			'{0, 0, 0},          // both pedals idle
			'{4096, 4096, 1800}, // both pedals pressed
			'{205, 0, 450},      // front exactly on the deadband
			'{0, 205, 2000},     // back exactly on the deadband
			'{205, 205, 900},    // both on the deadband
			'{4096, 0, 0},
			'{4096, 0, 450},
			'{4096, 0, 900},
			'{4096, 0, 901},
			'{4096, 0, 1800},
			'{4096, 0, 1801},
			'{4096, 0, 2700},
			'{4096, 0, 2701},
			'{4096, 0, 3600},
			'{4096, 0, 3601},    // forward past the last sector
			'{8191, 204, 4095},  // widest front field and angle
			'{0, 4096, 900},     // straight reverse
			'{0, 4096, 0},       // reverse with no sector
			'{0, 4096, 1800},
			'{0, 4096, 1801},
			'{0, 4096, 2250},
			'{100, 4096, 2700},
			'{0, 4096, 2701},
			'{0, 8191, 3600},    // widest back field
			'{206, 0, 1234}      // just past the deadband
		};
		int ms_set[7] = '{1000, 0, 10000, 16383, 16383, 1, 0};
		int db_set[7] = '{205, 0, 4096, 8191, 0, 1, 0};
		int cur_db;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_set[i])
			push_sample(pack_sample(dir_set[i][0], dir_set[i][1], dir_set[i][2]));

		ms_set[6] = $urandom_range(10000, 500);
		db_set[6] = $urandom_range(400, 0);

		for (int ph = 0; ph < 7; ph++) begin
			cur_db = db_set[ph];
			if (ph > 0) begin
				drain_pipe();
				write_reg(jtws_pkg::REG_FULL_SCALE, ms_set[ph]);
				write_reg(jtws_pkg::REG_DEADBAND, db_set[ph]);
			end else begin
				// Stall the output for a long stretch while samples keep coming,
				// so the pipeline fills and the input backs up.
				choke_req = 1'b1;
				tx_rush = 1'b1;
				repeat (30) push_sample(make_sample(cur_db));
				tx_rush = 1'b0;
			end
			repeat (PHASE_ITEMS) push_sample(make_sample(cur_db));
		end

		drain_pipe();
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/jtws_pkg.sv
sv/jtws_decode.sv
sv/jtws_arith.sv
sv/jtws_out.sv
sv/joystick_to_wheel_speed_mixer.sv
verif/wheel_mix_checker.sv
verif/testbench.sv
